// File: sv/qal_pkg.sv
// Shared types and constants of the quadratic adaptive low-pass filter.
`timescale 1ns / 1ps

package qal_pkg;

   // Threshold register and derived widths
   localparam int THR_WIDTH = 23;
   localparam int DIV_WIDTH = 2 * THR_WIDTH;

   // Running difference and magnitude widths (cover sample widths up to 32)
   localparam int RD_WIDTH  = 32;
   localparam int DF_WIDTH  = 33;
   localparam int SUM_WIDTH = 34;

   // Q12 blend weight
   localparam int WGT_FRAC  = 11;
   localparam int WGT_WIDTH = 13;
   localparam int Q_SHIFT   = 12;
   localparam logic [WGT_WIDTH-1:0] WGT_ONE  = 13'd4096;
   localparam logic [WGT_WIDTH-1:0] WGT_HALF = 13'd2048;

   // Register map
   localparam logic REG_THRESHOLD  = 1'b0;
   localparam logic REG_ACCUMULATE = 1'b1;
   localparam logic [THR_WIDTH-1:0] THR_RESET = 23'd4096;
   localparam logic ACC_RESET = 1'b1;

   typedef struct packed {
      logic [THR_WIDTH-1:0] move_threshold;
      logic                 accumulate_enable;
   } qal_cfg_type;

   typedef struct packed {
      logic busy;
      logic done;
   } qal_unit_stat_type;

endpackage

// File: sv/quadratic_adaptive_lowpass.sv
// Top level of the quadratic adaptive low-pass filter.
// Usage:
//   A request carries the present filtered value and a new raw sample (signed
//   Q12); each request yields one response holding the blended value.
//   Both channels are valid/ready; the APB port sets the movement threshold
//   (address 0) and the accumulate mode (address 4). The user must write them
//   only while the block is idle; the block itself does not enforce this.
//   An accepted request passes the difference, accumulate, magnitude and range
//   steps. At or above twice the threshold the radix-4 blend multiplier runs
//   alone; below the threshold the radix-4 squarers, the one-bit-per-cycle
//   divider and the blend multiplier run one after another, and in between the
//   divider, a squarer and the blend multiplier, for one request at a time.
//   A new request is taken only once the last one has left the final step.
// Reset:
//   Synchronous reset clears the running difference, the sequencer and the
//   response valid; the threshold returns to 4096 and accumulation is on.
// Stall:
//   A response waits in the output register while rsp_ready is low; the next
//   request may be accepted and worked on meanwhile, and its result holds in
//   the last step until the output register frees.
`timescale 1ns / 1ps

module quadratic_adaptive_lowpass import qal_pkg::*; #(
   parameter int SAMPLE_WIDTH = 24
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic signed [SAMPLE_WIDTH-1:0] req_current_value,
   input  logic signed [SAMPLE_WIDTH-1:0] req_new_sample,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_filtered_value,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [2:0]                     paddr,
   input  logic [31:0]                    pwdata,
   output logic [31:0]                    prdata,
   output logic                           pready
);

   localparam int W  = SAMPLE_WIDTH;
   localparam int PW = W + 1 + WGT_WIDTH;

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_DIFF  = 4'd1;
   localparam logic [3:0] ST_ACCUM = 4'd2;
   localparam logic [3:0] ST_MAG   = 4'd3;
   localparam logic [3:0] ST_RANGE = 4'd4;
   localparam logic [3:0] ST_SQ    = 4'd5;
   localparam logic [3:0] ST_DIV1  = 4'd6;
   localparam logic [3:0] ST_DIV2  = 4'd7;
   localparam logic [3:0] ST_TSQ   = 4'd8;
   localparam logic [3:0] ST_BLEND = 4'd9;
   localparam logic [3:0] ST_FIN1  = 4'd10;
   localparam logic [3:0] ST_FIN2  = 4'd11;

   qal_cfg_type cfg;

   logic [3:0]                   state_ff, state_in;
   logic signed [W-1:0]          cur_ff, cur_in;
   logic signed [W-1:0]          val_ff, val_in;
   logic signed [W:0]            diff_ff, diff_in;
   logic signed [RD_WIDTH-1:0]   rd_ff, rd_in;
   logic signed [DF_WIDTH-1:0]   d_ff, d_in;
   logic [DF_WIDTH-1:0]          df_ff, df_in;
   logic [W:0]                   adiff_ff, adiff_in;
   logic signed [W+1:0]          adj_ff, adj_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic signed [W-1:0]          rsp_value_ff, rsp_value_in;

   logic signed [SUM_WIDTH-1:0]  acc_sum;
   logic [SUM_WIDTH-RD_WIDTH:0]  acc_top;
   logic signed [RD_WIDTH-1:0]   rd_sat;
   logic                         same_sign;
   logic [DF_WIDTH-1:0]          thr_x, thr2_x, df_minus_thr;
   logic                         lt1, lt2;
   logic [WGT_WIDTH-1:0]         t_mag;
   logic [WGT_WIDTH-1:0]         w_start;
   logic signed [PW:0]           blend_s, blend_n, blend_sh;
   logic signed [W+1:0]          out_sum;

   logic                         sq_start, thr_start, div_start, blend_start;
   logic [THR_WIDTH-1:0]         sq_op;
   logic [DIV_WIDTH-1:0]         div_rem, div_dvs;
   logic [DIV_WIDTH-1:0]         sq_prod, thr_prod;
   logic [WGT_FRAC-1:0]          div_q;
   logic [PW-1:0]                blend_prod;
   qal_unit_stat_type            sq_stat, thr_stat, div_stat, blend_stat;

   qal_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   qal_serial_mult #(.AW(THR_WIDTH), .BW(THR_WIDTH)) u_sq_mult (
      .clock   (clock),
      .reset   (reset),
      .start   (sq_start),
      .mcand   (sq_op),
      .mplier  (sq_op),
      .product (sq_prod),
      .stat    (sq_stat)
   );

   qal_serial_mult #(.AW(THR_WIDTH), .BW(THR_WIDTH)) u_thr_mult (
      .clock   (clock),
      .reset   (reset),
      .start   (thr_start),
      .mcand   (cfg.move_threshold),
      .mplier  (cfg.move_threshold),
      .product (thr_prod),
      .stat    (thr_stat)
   );

   qal_serial_div #(.RW(DIV_WIDTH), .NB(WGT_FRAC)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .rem_init (div_rem),
      .divisor  (div_dvs),
      .quotient (div_q),
      .stat     (div_stat)
   );

   qal_serial_mult #(.AW(W + 1), .BW(WGT_WIDTH)) u_blend_mult (
      .clock   (clock),
      .reset   (reset),
      .start   (blend_start),
      .mcand   (adiff_ff),
      .mplier  (w_start),
      .product (blend_prod),
      .stat    (blend_stat)
   );

   // Running difference update with saturation to 32 bits
   assign same_sign = (diff_ff[W] && rd_ff[RD_WIDTH-1]) ||
                      (!diff_ff[W] && (diff_ff != '0) &&
                       !rd_ff[RD_WIDTH-1] && (rd_ff != '0));
   assign acc_sum = same_sign ? SUM_WIDTH'(rd_ff) + SUM_WIDTH'(diff_ff)
                              : SUM_WIDTH'(diff_ff);
   assign acc_top = acc_sum[SUM_WIDTH-1:RD_WIDTH-1];

   always_comb begin
      if ((&acc_top) || !(|acc_top)) begin
         rd_sat = acc_sum[RD_WIDTH-1:0];
      end else if (acc_sum[SUM_WIDTH-1]) begin
         rd_sat = {1'b1, {(RD_WIDTH-1){1'b0}}};
      end else begin
         rd_sat = {1'b0, {(RD_WIDTH-1){1'b1}}};
      end
   end

   // Threshold comparisons for the weight curve
   assign thr_x        = DF_WIDTH'(cfg.move_threshold);
   assign thr2_x       = DF_WIDTH'({cfg.move_threshold, 1'b0});
   assign lt1          = df_ff < thr_x;
   assign lt2          = df_ff < thr2_x;
   assign df_minus_thr = df_ff - thr_x;

   // Distance of the ratio from two, in Q11
   assign t_mag = WGT_HALF - WGT_WIDTH'(div_q);

   // Unit start strobes and operands
   always_comb begin
      sq_start    = 1'b0;
      thr_start   = 1'b0;
      div_start   = 1'b0;
      blend_start = 1'b0;
      sq_op       = df_ff[THR_WIDTH-1:0];
      div_rem     = DIV_WIDTH'(df_minus_thr[THR_WIDTH-1:0]);
      div_dvs     = DIV_WIDTH'(cfg.move_threshold);
      w_start     = WGT_ONE;
      case (state_ff)
         ST_RANGE: begin
            if (lt1) begin
               sq_start  = 1'b1;
               thr_start = 1'b1;
            end else if (lt2) begin
               div_start = 1'b1;
            end else begin
               blend_start = 1'b1;
            end
         end
         ST_SQ: begin
            div_rem   = sq_prod;
            div_dvs   = thr_prod;
            div_start = sq_stat.done;
         end
         ST_DIV1: begin
            w_start     = WGT_WIDTH'(div_q);
            blend_start = div_stat.done;
         end
         ST_DIV2: begin
            sq_op    = THR_WIDTH'(t_mag);
            sq_start = div_stat.done;
         end
         ST_TSQ: begin
            w_start     = WGT_ONE - sq_prod[WGT_FRAC+WGT_WIDTH-1:WGT_FRAC];
            blend_start = sq_stat.done;
         end
         default: begin
            sq_start = 1'b0;
         end
      endcase
   end

   // Signed blend correction, floor-shifted by 12
   assign blend_s  = $signed({1'b0, blend_prod});
   assign blend_n  = diff_ff[W] ? -blend_s : blend_s;
   assign blend_sh = blend_n >>> Q_SHIFT;
   assign out_sum  = (W+2)'(cur_ff) + adj_ff;

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      val_in       = val_ff;
      diff_in      = diff_ff;
      rd_in        = rd_ff;
      d_in         = d_ff;
      df_in        = df_ff;
      adiff_in     = adiff_ff;
      adj_in       = adj_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cur_in   = req_current_value;
               val_in   = req_new_sample;
               state_in = ST_DIFF;
            end
         end
         ST_DIFF: begin
            diff_in  = (W+1)'(val_ff) - (W+1)'(cur_ff);
            state_in = ST_ACCUM;
         end
         ST_ACCUM: begin
            if (cfg.accumulate_enable) begin
               rd_in = rd_sat;
               d_in  = DF_WIDTH'(rd_sat);
            end else begin
               d_in  = DF_WIDTH'(diff_ff);
            end
            state_in = ST_MAG;
         end
         ST_MAG: begin
            df_in    = d_ff[DF_WIDTH-1] ? DF_WIDTH'(-d_ff) : DF_WIDTH'(d_ff);
            adiff_in = diff_ff[W] ? (W+1)'(-diff_ff) : (W+1)'(diff_ff);
            state_in = ST_RANGE;
         end
         ST_RANGE: begin
            if (lt1) begin
               state_in = ST_SQ;
            end else if (lt2) begin
               state_in = ST_DIV2;
            end else begin
               state_in = ST_BLEND;
            end
         end
         ST_SQ: begin
            if (sq_stat.done) begin
               state_in = ST_DIV1;
            end
         end
         ST_DIV1: begin
            if (div_stat.done) begin
               state_in = ST_BLEND;
            end
         end
         ST_DIV2: begin
            if (div_stat.done) begin
               state_in = ST_TSQ;
            end
         end
         ST_TSQ: begin
            if (sq_stat.done) begin
               state_in = ST_BLEND;
            end
         end
         ST_BLEND: begin
            if (blend_stat.done) begin
               state_in = ST_FIN1;
            end
         end
         ST_FIN1: begin
            adj_in   = blend_sh[W+1:0];
            state_in = ST_FIN2;
         end
         ST_FIN2: begin
            // Hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_value_in = out_sum[W-1:0];
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_ff        <= rd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff       <= cur_in;
      val_ff       <= val_in;
      diff_ff      <= diff_in;
      d_ff         <= d_in;
      df_ff        <= df_in;
      adiff_ff     <= adiff_in;
      adj_ff       <= adj_in;
      rsp_value_ff <= rsp_value_in;
   end

   assign req_ready          = (state_ff == ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_filtered_value = rsp_value_ff;

   // A response appears only from the final step
   a_rsp_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FIN2))
      else $error("response raised outside the final step");

   // Both squarers run in lockstep in the lower range
   a_sq_lockstep: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SQ) |-> (sq_stat.busy == thr_stat.busy))
      else $error("squarers out of step");

   // Divider finishes only while the sequencer waits on it
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> (state_ff == ST_DIV1 || state_ff == ST_DIV2))
      else $error("divider finished in an unexpected step");

   // Blend multiplier runs only in the blend step
   a_blend_busy: assert property (@(posedge clock) disable iff (reset)
      blend_stat.busy |-> (state_ff == ST_BLEND))
      else $error("blend multiplier busy outside the blend step");

   // Weight never exceeds one
   a_weight_max: assert property (@(posedge clock) disable iff (reset)
      blend_start |-> (w_start <= WGT_ONE))
      else $error("blend weight above one");

endmodule

// File: sv/qal_csr.sv
// APB register block holding the threshold and accumulate mode.
`timescale 1ns / 1ps

module qal_csr import qal_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready,
   output qal_cfg_type cfg
);

   logic [THR_WIDTH-1:0] thr_ff, thr_in;
   logic                 acc_ff, acc_in;
   logic                 wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel & penable & pwrite;

   // Decode the register write by word index
   always_comb begin
      thr_in = thr_ff;
      acc_in = acc_ff;
      if (wr_en) begin
         case (paddr[2])
            REG_THRESHOLD:  thr_in = pwdata[THR_WIDTH-1:0];
            REG_ACCUMULATE: acc_in = pwdata[0];
            default:        thr_in = thr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_RESET;
         acc_ff <= ACC_RESET;
      end else begin
         thr_ff <= thr_in;
         acc_ff <= acc_in;
      end
   end

   // Read back
   always_comb begin
      case (paddr[2])
         REG_THRESHOLD:  prdata = 32'(thr_ff);
         REG_ACCUMULATE: prdata = 32'(acc_ff);
         default:        prdata = '0;
      endcase
   end

   assign cfg.move_threshold    = thr_ff;
   assign cfg.accumulate_enable = acc_ff;

endmodule

// File: sv/qal_serial_mult.sv
// Radix-4 shift-and-add multiplier, two multiplier bits per cycle.
`timescale 1ns / 1ps

module qal_serial_mult import qal_pkg::*; #(
   parameter int AW = 23,
   parameter int BW = 23
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [AW-1:0]      mcand,
   input  logic [BW-1:0]      mplier,
   output logic [AW+BW-1:0]   product,
   output qal_unit_stat_type  stat
);

   localparam int BWE   = BW + (BW % 2);
   localparam int STEPS = BWE / 2;
   localparam int CW    = $clog2(STEPS + 1);
   localparam int PW    = AW + BWE;

   logic [AW-1:0]  a_ff, a_in;
   logic [AW+1:0]  a3_ff, a3_in;
   logic [BWE-1:0] b_ff, b_in;
   logic [PW-1:0]  acc_ff, acc_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic           busy_ff, busy_in;
   logic           done_ff, done_in;
   logic [PW-1:0]  addend;

   // Select the partial product for the leading digit
   always_comb begin
      case (b_ff[BWE-1 -: 2])
         2'd1:    addend = PW'(a_ff);
         2'd2:    addend = PW'({a_ff, 1'b0});
         2'd3:    addend = PW'(a3_ff);
         default: addend = '0;
      endcase
   end

   always_comb begin
      a_in    = a_ff;
      a3_in   = a3_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         // Load operands and the triple multiple
         a_in    = mcand;
         a3_in   = (AW+2)'(mcand) + (AW+2)'({mcand, 1'b0});
         b_in    = BWE'(mplier);
         acc_in  = '0;
         cnt_in  = CW'(STEPS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // Advance one digit, most significant first
         acc_in = {acc_ff[PW-3:0], 2'b00} + addend;
         b_in   = {b_ff[BWE-3:0], 2'b00};
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      a3_ff  <= a3_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
   end

   assign product   = acc_ff[AW+BW-1:0];
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

// File: sv/qal_serial_div.sv
// Restoring fractional divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module qal_serial_div import qal_pkg::*; #(
   parameter int RW = 46,
   parameter int NB = 11
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [RW-1:0]     rem_init,
   input  logic [RW-1:0]     divisor,
   output logic [NB-1:0]     quotient,
   output qal_unit_stat_type stat
);

   localparam int CW = $clog2(NB + 1);

   logic [RW-1:0] r_ff, r_in;
   logic [RW-1:0] d_ff, d_in;
   logic [NB-1:0] q_ff, q_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [RW:0]   r_shift;
   logic [RW:0]   r_sub;
   logic          ge;

   // Trial subtract of the doubled remainder
   assign r_shift = {r_ff, 1'b0};
   assign r_sub   = r_shift - {1'b0, d_ff};
   assign ge      = !r_sub[RW];

   always_comb begin
      r_in    = r_ff;
      d_in    = d_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         r_in    = rem_init;
         d_in    = divisor;
         q_in    = '0;
         cnt_in  = CW'(NB);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // Keep the remainder below the divisor
         r_in   = ge ? r_sub[RW-1:0] : r_shift[RW-1:0];
         q_in   = {q_ff[NB-2:0], ge};
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      r_ff <= r_in;
      d_ff <= d_in;
      q_ff <= q_in;
   end

   assign quotient  = q_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule
